FILE: src/assert_macros.svh
// Assertion helpers, clocked on clk with asynchronous reset arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define GBNS_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define GBNS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define GBNS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/gbns_pkg.sv
package gbns_pkg;

	localparam int WINDOW       = 4;
	localparam int SEQ_BITS     = 3;
	localparam int PAYLOAD_BITS = 32;
	localparam int WIN_BITS     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNT_BITS     = $clog2(WINDOW + 1);

	localparam int Q_DEPTH    = 2;
	localparam int Q_PTR_BITS = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

	localparam logic [1:0] REQ_SEND    = 2'd0;
	localparam logic [1:0] REQ_ACK     = 2'd1;
	localparam logic [1:0] REQ_TIMEOUT = 2'd2;

	localparam logic [1:0] TMR_NONE    = 2'd0;
	localparam logic [1:0] TMR_START   = 2'd1;
	localparam logic [1:0] TMR_STOP    = 2'd2;
	localparam logic [1:0] TMR_RESTART = 2'd3;

	typedef struct packed {
		logic                    accepted;
		logic                    pkt_valid;
		logic [SEQ_BITS-1:0]     pkt_seq;
		logic [PAYLOAD_BITS-1:0] pkt_payload;
		logic [1:0]              timer_cmd;
		logic [SEQ_BITS-1:0]     timer_seq;
		logic                    window_full;
		logic                    last;
	} rsp_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic logic [WIN_BITS-1:0] wrap_add(input logic [WIN_BITS-1:0] a,
			input logic [CNT_BITS-1:0] b);
		logic [CNT_BITS:0] s;
		s = CNT_BITS'(a) + CNT_BITS'(b);
		if (s >= (CNT_BITS + 1)'(WINDOW)) begin
			s = s - (CNT_BITS + 1)'(WINDOW);
		end
		return s[WIN_BITS-1:0];
	endfunction

endpackage

FILE: src/gbns_front.sv
`include "assert_macros.svh"

module gbns_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_ready,
	input  logic [1:0]                       req_type,
	input  logic [gbns_pkg::PAYLOAD_BITS-1:0] payload,
	input  logic [gbns_pkg::SEQ_BITS-1:0]    seq_num,
	input  logic                             ack_ok,
	input  gbns_pkg::q_status_t              q_status,
	output logic                             q_push,
	output gbns_pkg::rsp_t                   q_data
);

	typedef enum logic [1:0] {
		ST_IDLE   = 2'b01,
		ST_RESEND = 2'b10
	} state_t;

	state_t                                  state_q;
	logic [gbns_pkg::SEQ_BITS-1:0]           next_seq_q;
	logic [gbns_pkg::CNT_BITS-1:0]           outst_q;
	logic [gbns_pkg::WIN_BITS-1:0]           head_q;
	logic [gbns_pkg::CNT_BITS-1:0]           cnt_q;
	logic [gbns_pkg::PAYLOAD_BITS-1:0]       ring_q [gbns_pkg::WINDOW];

	logic [gbns_pkg::SEQ_BITS-1:0] base;
	logic [gbns_pkg::SEQ_BITS-1:0] ack_k;
	logic                          ack_hit;
	logic [gbns_pkg::CNT_BITS-1:0] freed;
	logic [gbns_pkg::CNT_BITS-1:0] outst_d;
	logic [gbns_pkg::WIN_BITS-1:0] head_d;
	logic [gbns_pkg::SEQ_BITS-1:0] next_seq_d;
	logic [gbns_pkg::WIN_BITS-1:0] rd_idx;
	logic [gbns_pkg::WIN_BITS-1:0] wr_idx;
	logic                          wr_en;
	logic                          win_full;
	logic                          take;
	logic                          resend_last;
	state_t                        state_d;
	logic [gbns_pkg::CNT_BITS-1:0] cnt_d;

	assign win_full  = outst_q >= gbns_pkg::CNT_BITS'(gbns_pkg::WINDOW);
	assign base      = next_seq_q - gbns_pkg::SEQ_BITS'(outst_q);
	assign ack_k     = seq_num - base;
	assign ack_hit   = ack_ok && (outst_q != '0)
		&& ((gbns_pkg::CNT_BITS + gbns_pkg::SEQ_BITS)'(ack_k)
		< (gbns_pkg::CNT_BITS + gbns_pkg::SEQ_BITS)'(outst_q));
	assign freed     = gbns_pkg::CNT_BITS'(ack_k) + gbns_pkg::CNT_BITS'(1);
	assign rd_idx    = gbns_pkg::wrap_add(head_q, (state_q == ST_RESEND) ? cnt_q : '0);
	assign wr_idx    = gbns_pkg::wrap_add(head_q, outst_q);
	assign req_ready = (state_q == ST_IDLE) && !q_status.full;
	assign take      = req_valid && req_ready;
	assign resend_last = (cnt_q + gbns_pkg::CNT_BITS'(1)) == outst_q;

	always_comb begin
		q_push     = 1'b0;
		q_data     = '0;
		q_data.accepted = 1'b1;
		q_data.last     = 1'b1;
		q_data.window_full = win_full;
		outst_d    = outst_q;
		head_d     = head_q;
		next_seq_d = next_seq_q;
		wr_en      = 1'b0;
		state_d    = state_q;
		cnt_d      = cnt_q;
		unique case (state_q)
			ST_IDLE: begin
				q_push = take;
				if (take) begin
					unique case (req_type)
						gbns_pkg::REQ_SEND: begin
							if (win_full) begin
								q_data.accepted = 1'b0;
							end else begin
								wr_en      = 1'b1;
								outst_d    = outst_q + gbns_pkg::CNT_BITS'(1);
								next_seq_d = next_seq_q + gbns_pkg::SEQ_BITS'(1);
								q_data.pkt_valid   = 1'b1;
								q_data.pkt_seq     = next_seq_q;
								q_data.pkt_payload = payload;
								if (outst_q == '0) begin
									q_data.timer_cmd = gbns_pkg::TMR_START;
									q_data.timer_seq = next_seq_q;
								end
								q_data.window_full =
									outst_d >= gbns_pkg::CNT_BITS'(gbns_pkg::WINDOW);
							end
						end
						gbns_pkg::REQ_ACK: begin
							if (ack_hit) begin
								outst_d = outst_q - freed;
								head_d  = gbns_pkg::wrap_add(head_q, freed);
								if (outst_d == '0) begin
									q_data.timer_cmd = gbns_pkg::TMR_STOP;
									q_data.timer_seq = base;
								end else begin
									q_data.timer_cmd = gbns_pkg::TMR_RESTART;
									q_data.timer_seq = seq_num + gbns_pkg::SEQ_BITS'(1);
								end
								q_data.window_full =
									outst_d >= gbns_pkg::CNT_BITS'(gbns_pkg::WINDOW);
							end
						end
						gbns_pkg::REQ_TIMEOUT: begin
							q_data.timer_cmd = gbns_pkg::TMR_RESTART;
							q_data.timer_seq = seq_num;
							if (outst_q != '0) begin
								q_data.pkt_valid   = 1'b1;
								q_data.pkt_seq     = base;
								q_data.pkt_payload = ring_q[rd_idx];
								q_data.last        = outst_q == gbns_pkg::CNT_BITS'(1);
								if (outst_q != gbns_pkg::CNT_BITS'(1)) begin
									state_d = ST_RESEND;
									cnt_d   = gbns_pkg::CNT_BITS'(1);
								end
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_RESEND: begin
				q_push = !q_status.full;
				q_data.pkt_valid   = 1'b1;
				q_data.pkt_seq     = base + gbns_pkg::SEQ_BITS'(cnt_q);
				q_data.pkt_payload = ring_q[rd_idx];
				q_data.last        = resend_last;
				if (q_push) begin
					cnt_d = cnt_q + gbns_pkg::CNT_BITS'(1);
					if (resend_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			next_seq_q <= '0;
			outst_q    <= '0;
			head_q     <= '0;
			cnt_q      <= '0;
		end else begin
			state_q    <= state_d;
			next_seq_q <= next_seq_d;
			outst_q    <= outst_d;
			head_q     <= head_d;
			cnt_q      <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ring_q[wr_idx] <= payload;
		end
	end

	`GBNS_ASSERT(a_outst_bound, outst_q <= gbns_pkg::CNT_BITS'(gbns_pkg::WINDOW), "outstanding count exceeds window")
	`GBNS_ASSERT_IMP(a_resend_blocks, state_q == ST_RESEND, !req_ready && outst_q > gbns_pkg::CNT_BITS'(1), "input taken or bad count during resend")
	`GBNS_ASSERT_IMP(a_no_push_full, q_status.full, !q_push, "push into full queue")
	`GBNS_ASSERT_NXT(a_resend_holds, state_q == ST_RESEND, $stable(outst_q) && $stable(next_seq_q), "window changed during resend")

endmodule

FILE: src/gbns_queue.sv
module gbns_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  gbns_pkg::rsp_t      push_data,
	input  logic                pop,
	output gbns_pkg::rsp_t      pop_data,
	output gbns_pkg::q_status_t status
);

	gbns_pkg::rsp_t                   mem_q [gbns_pkg::Q_DEPTH];
	logic [gbns_pkg::Q_PTR_BITS-1:0]  wr_ptr_q;
	logic [gbns_pkg::Q_PTR_BITS-1:0]  rd_ptr_q;
	logic [gbns_pkg::Q_CNT_BITS-1:0]  count_q;

	function automatic logic [gbns_pkg::Q_PTR_BITS-1:0] ptr_inc(
			input logic [gbns_pkg::Q_PTR_BITS-1:0] p);
		if (p == gbns_pkg::Q_PTR_BITS'(gbns_pkg::Q_DEPTH - 1)) begin
			return '0;
		end
		return p + gbns_pkg::Q_PTR_BITS'(1);
	endfunction

	assign status.full  = count_q == gbns_pkg::Q_CNT_BITS'(gbns_pkg::Q_DEPTH);
	assign status.empty = count_q == '0;
	assign pop_data     = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + gbns_pkg::Q_CNT_BITS'(1);
			end else if (pop && !push) begin
				count_q <= count_q - gbns_pkg::Q_CNT_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

FILE: src/gbns_back.sv
module gbns_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  gbns_pkg::q_status_t               q_status,
	input  gbns_pkg::rsp_t                    q_data,
	output logic                              q_pop,
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	output logic                              accepted,
	output logic                              pkt_valid,
	output logic [gbns_pkg::SEQ_BITS-1:0]     pkt_seq,
	output logic [gbns_pkg::PAYLOAD_BITS-1:0] pkt_payload,
	output logic [1:0]                        timer_cmd,
	output logic [gbns_pkg::SEQ_BITS-1:0]     timer_seq,
	output logic                              window_full,
	output logic                              last
);

	logic           valid_q;
	gbns_pkg::rsp_t data_q;

	assign q_pop = !q_status.empty && (!valid_q || rsp_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || rsp_ready) begin
			valid_q <= !q_status.empty;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			data_q <= q_data;
		end
	end

	assign rsp_valid   = valid_q;
	assign accepted    = data_q.accepted;
	assign pkt_valid   = data_q.pkt_valid;
	assign pkt_seq     = data_q.pkt_seq;
	assign pkt_payload = data_q.pkt_payload;
	assign timer_cmd   = data_q.timer_cmd;
	assign timer_seq   = data_q.timer_seq;
	assign window_full = data_q.window_full;
	assign last        = data_q.last;

endmodule

FILE: src/go_back_n_sender_core.sv
// Go-Back-N sender, window of 4 packets, 3-bit sequence numbers.
// Request channel (req_valid/req_ready): req_type selects send, ack or timer
// expiry; payload, seq_num and ack_ok go with it. Result channel
// (rsp_valid/rsp_ready) carries one result per transfer; last marks the final
// result of a request.
// Send, ack and unknown requests give one result each; a timeout gives one result
// per outstanding packet (up to 4), oldest first, the first also carrying a timer
// restart, or a single timer-restart result when no packet is outstanding.
// A result passes through the queue and the output register before it is offered.
// Throughput: one request per cycle for send and ack while the queue has room; a
// timeout with outstanding packets holds the request side until all are resent,
// one payload read from the window buffer per cycle while the queue has room.
// A 2-entry queue sits between the request logic and the output register, so
// requests keep flowing while a result waits; when the receiver stalls, the
// queue fills and req_ready drops.
// Reset clears the sequence counter, the outstanding count and all valids;
// the window buffer needs no clearing.
module go_back_n_sender_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  logic [1:0]                        req_type,
	input  logic [gbns_pkg::PAYLOAD_BITS-1:0] payload,
	input  logic [gbns_pkg::SEQ_BITS-1:0]     seq_num,
	input  logic                              ack_ok,
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	output logic                              accepted,
	output logic                              pkt_valid,
	output logic [gbns_pkg::SEQ_BITS-1:0]     pkt_seq,
	output logic [gbns_pkg::PAYLOAD_BITS-1:0] pkt_payload,
	output logic [1:0]                        timer_cmd,
	output logic [gbns_pkg::SEQ_BITS-1:0]     timer_seq,
	output logic                              window_full,
	output logic                              last
);

	gbns_pkg::q_status_t q_status;
	gbns_pkg::rsp_t      push_data;
	gbns_pkg::rsp_t      pop_data;
	logic                q_push;
	logic                q_pop;

	gbns_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_type  (req_type),
		.payload   (payload),
		.seq_num   (seq_num),
		.ack_ok    (ack_ok),
		.q_status  (q_status),
		.q_push    (q_push),
		.q_data    (push_data)
	);

	gbns_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_data),
		.pop       (q_pop),
		.pop_data  (pop_data),
		.status    (q_status)
	);

	gbns_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_status    (q_status),
		.q_data      (pop_data),
		.q_pop       (q_pop),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.accepted    (accepted),
		.pkt_valid   (pkt_valid),
		.pkt_seq     (pkt_seq),
		.pkt_payload (pkt_payload),
		.timer_cmd   (timer_cmd),
		.timer_seq   (timer_seq),
		.window_full (window_full),
		.last        (last)
	);

endmodule

FILE: verif/go_back_n_sender_core_tb.sv
`timescale 1ns / 1ps

module go_back_n_sender_core_tb;

	localparam logic [1:0] REQ_BOGUS = 2'd3;

	typedef struct {
		logic [1:0]                        kind;
		logic [gbns_pkg::PAYLOAD_BITS-1:0] pay;
		logic [gbns_pkg::SEQ_BITS-1:0]     sn;
		logic                              ok;
		bit                                typed;
		gbns_pkg::rsp_t                    want;
	} step_t;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              req_valid = 1'b0;
	logic                              req_ready;
	logic [1:0]                        req_type = gbns_pkg::REQ_SEND;
	logic [gbns_pkg::PAYLOAD_BITS-1:0] payload = '0;
	logic [gbns_pkg::SEQ_BITS-1:0]     seq_num = '0;
	logic                              ack_ok = 1'b0;
	logic                              rsp_valid;
	logic                              rsp_ready = 1'b0;
	logic                              accepted;
	logic                              pkt_valid;
	logic [gbns_pkg::SEQ_BITS-1:0]     pkt_seq;
	logic [gbns_pkg::PAYLOAD_BITS-1:0] pkt_payload;
	logic [1:0]                        timer_cmd;
	logic [gbns_pkg::SEQ_BITS-1:0]     timer_seq;
	logic                              window_full;
	logic                              last;

	always #4 clk = ~clk;

	go_back_n_sender_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_type(req_type),
		.payload(payload),
		.seq_num(seq_num),
		.ack_ok(ack_ok),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.accepted(accepted),
		.pkt_valid(pkt_valid),
		.pkt_seq(pkt_seq),
		.pkt_payload(pkt_payload),
		.timer_cmd(timer_cmd),
		.timer_seq(timer_seq),
		.window_full(window_full),
		.last(last)
	);

	// sender state mirror
	logic [gbns_pkg::SEQ_BITS-1:0]     snd_next = '0;
	int unsigned                       in_flight = 0;
	logic [gbns_pkg::PAYLOAD_BITS-1:0] held_pay [gbns_pkg::WINDOW];

	gbns_pkg::rsp_t due_rsp [$];
	int   errors = 0;
	int   rsp_cnt = 0;
	int   kind_cnt [4] = '{0, 0, 0, 0};
	int   req_cnt = 0;

	function automatic logic [gbns_pkg::SEQ_BITS-1:0] oldest_seq();
		return snd_next - gbns_pkg::SEQ_BITS'(in_flight);
	endfunction

	function automatic gbns_pkg::rsp_t mk_rsp(logic acc, logic pv,
			logic [gbns_pkg::SEQ_BITS-1:0] seq, logic [gbns_pkg::PAYLOAD_BITS-1:0] pay,
			logic [1:0] tcmd, logic [gbns_pkg::SEQ_BITS-1:0] tseq, logic wf, logic lst);
		gbns_pkg::rsp_t r;
		r.accepted    = acc;
		r.pkt_valid   = pv;
		r.pkt_seq     = seq;
		r.pkt_payload = pay;
		r.timer_cmd   = tcmd;
		r.timer_seq   = tseq;
		r.window_full = wf;
		r.last        = lst;
		return r;
	endfunction

	function automatic int pause_draw(int n, int period, int quiet);
		return ((n % period) < quiet) ? 0 : int'($urandom_range(0, 4));
	endfunction

	function automatic void cmp_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
		if (act_v !== exp_v) begin
			errors++;
			$display("%0t ns: %s expected %0h, got %0h", $time, name, exp_v, act_v);
		end
	endfunction

	// window model: updates state, returns the results one request causes
	task automatic gbn_predict(input logic [1:0] kind,
			input logic [gbns_pkg::PAYLOAD_BITS-1:0] pay,
			input logic [gbns_pkg::SEQ_BITS-1:0] sn, input logic ok, output bit acted,
			ref gbns_pkg::rsp_t res [$]);
		logic [gbns_pkg::SEQ_BITS-1:0] base;
		logic [gbns_pkg::SEQ_BITS-1:0] span_k;
		int unsigned                   freed;
		base = oldest_seq();
		acted = 1'b1;
		res.delete();
		case (kind)
			gbns_pkg::REQ_SEND: begin
				if (in_flight >= gbns_pkg::WINDOW) begin
					acted = 1'b0;
					res = {res, mk_rsp(0, 0, 0, 0, gbns_pkg::TMR_NONE, 0, 1, 1)};
				end else begin
					held_pay[in_flight] = pay;
					in_flight++;
					res = {res, mk_rsp(1, 1, snd_next, pay,
						(in_flight == 1) ? gbns_pkg::TMR_START : gbns_pkg::TMR_NONE,
						(in_flight == 1) ? snd_next : '0, in_flight >= gbns_pkg::WINDOW, 1)};
					snd_next++;
				end
			end
			gbns_pkg::REQ_ACK: begin
				span_k = sn - base;
				if (!ok || in_flight == 0 || span_k >= in_flight) begin
					acted = 1'b0;
					res = {res, mk_rsp(1, 0, 0, 0, gbns_pkg::TMR_NONE, 0,
						in_flight >= gbns_pkg::WINDOW, 1)};
				end else begin
					freed = int'(span_k) + 1;
					for (int i = 0; i + freed < in_flight; i++)
						held_pay[i] = held_pay[i + freed];
					in_flight -= freed;
					if (in_flight == 0)
						res = {res, mk_rsp(1, 0, 0, 0, gbns_pkg::TMR_STOP, base, 0, 1)};
					else
						res = {res, mk_rsp(1, 0, 0, 0, gbns_pkg::TMR_RESTART, oldest_seq(),
							0, 1)};
				end
			end
			gbns_pkg::REQ_TIMEOUT: begin
				if (in_flight == 0) begin
					res = {res, mk_rsp(1, 0, 0, 0, gbns_pkg::TMR_RESTART, sn, 0, 1)};
				end else begin
					for (int i = 0; i < in_flight; i++)
						res = {res, mk_rsp(1, 1, base + gbns_pkg::SEQ_BITS'(i), held_pay[i],
							(i == 0) ? gbns_pkg::TMR_RESTART : gbns_pkg::TMR_NONE,
							(i == 0) ? sn : '0,
							in_flight >= gbns_pkg::WINDOW, i == in_flight - 1)};
				end
			end
			default: begin
				acted = 1'b0;
				res = {res, mk_rsp(1, 0, 0, 0, gbns_pkg::TMR_NONE, 0,
					in_flight >= gbns_pkg::WINDOW, 1)};
			end
		endcase
	endtask

	// entered and left at a falling edge
	task automatic put_req(input logic [1:0] kind,
			input logic [gbns_pkg::PAYLOAD_BITS-1:0] pay,
			input logic [gbns_pkg::SEQ_BITS-1:0] sn, input logic ok, input bit typed,
			input gbns_pkg::rsp_t want, output bit acted);
		gbns_pkg::rsp_t res [$];
		int             gap;
		gap = pause_draw(req_cnt, 50, 12);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_type  <= kind;
		payload   <= pay;
		seq_num   <= sn;
		ack_ok    <= ok;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_ready !== 1'b1);
		gbn_predict(kind, pay, sn, ok, acted, res);
		if (typed)
			res[0] = want;
		foreach (res[i])
			due_rsp = {due_rsp, res[i]};
		req_cnt++;
		kind_cnt[kind]++;
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		gbns_pkg::rsp_t got;
		gbns_pkg::rsp_t want;
		if (arst_n && rsp_valid === 1'b1 && rsp_ready) begin
			got = {accepted, pkt_valid, pkt_seq, pkt_payload, timer_cmd, timer_seq,
				window_full, last};
			rsp_cnt++;
			if (due_rsp.size() == 0) begin
				errors++;
				$display("%0t ns: result transfer with none expected, got %p", $time, got);
			end else begin
				want = due_rsp.pop_front();
				cmp_field("accepted", want.accepted, got.accepted);
				cmp_field("pkt_valid", want.pkt_valid, got.pkt_valid);
				cmp_field("pkt_seq", want.pkt_seq, got.pkt_seq);
				cmp_field("pkt_payload", want.pkt_payload, got.pkt_payload);
				cmp_field("timer_cmd", want.timer_cmd, got.timer_cmd);
				cmp_field("timer_seq", want.timer_seq, got.timer_seq);
				cmp_field("window_full", want.window_full, got.window_full);
				cmp_field("last", want.last, got.last);
			end
		end
	end

	initial begin
		int taken;
		int stall;
		taken = 0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = pause_draw(taken, 60, 15);
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (rsp_valid !== 1'b1);
			taken++;
			@(negedge clk);
		end
	end

	initial begin
		#2_000_000;
		$display("go_back_n_sender_core verification failed");
		$finish;
	end

	initial begin
		step_t                             steps [24];
		bit                                acted;
		int                                useful;
		int                                pick;
		logic [1:0]                        kind;
		logic [gbns_pkg::PAYLOAD_BITS-1:0] pay;
		logic [gbns_pkg::SEQ_BITS-1:0]     sn;
		logic                              ok;

		steps = '{
			'{gbns_pkg::REQ_ACK, 32'h0, 3'd0, 1'b1, 1'b1,
				mk_rsp(1, 0, 0, 0, gbns_pkg::TMR_NONE, 0, 0, 1)},
			'{gbns_pkg::REQ_TIMEOUT, 32'h0, 3'd5, 1'b0, 1'b1,
				mk_rsp(1, 0, 0, 0, gbns_pkg::TMR_RESTART, 5, 0, 1)},
			'{REQ_BOGUS, 32'hFFFFFFFF, 3'd7, 1'b1, 1'b1,
				mk_rsp(1, 0, 0, 0, gbns_pkg::TMR_NONE, 0, 0, 1)},
			'{gbns_pkg::REQ_SEND, 32'h0, 3'd0, 1'b0, 1'b1,
				mk_rsp(1, 1, 0, 0, gbns_pkg::TMR_START, 0, 0, 1)},
			'{gbns_pkg::REQ_SEND, 32'hFFFFFFFF, 3'd7, 1'b1, 1'b1,
				mk_rsp(1, 1, 1, 32'hFFFFFFFF, gbns_pkg::TMR_NONE, 0, 0, 1)},
			'{gbns_pkg::REQ_SEND, 32'hA5A5A5A5, 3'd0, 1'b0, 1'b1,
				mk_rsp(1, 1, 2, 32'hA5A5A5A5, gbns_pkg::TMR_NONE, 0, 0, 1)},
			'{gbns_pkg::REQ_SEND, 32'h5A5A5A5A, 3'd0, 1'b0, 1'b1,
				mk_rsp(1, 1, 3, 32'h5A5A5A5A, gbns_pkg::TMR_NONE, 0, 1, 1)},
			'{gbns_pkg::REQ_SEND, 32'h12345678, 3'd0, 1'b0, 1'b1,
				mk_rsp(0, 0, 0, 0, gbns_pkg::TMR_NONE, 0, 1, 1)},
			'{gbns_pkg::REQ_ACK, 32'h0, 3'd1, 1'b0, 1'b1,
				mk_rsp(1, 0, 0, 0, gbns_pkg::TMR_NONE, 0, 1, 1)},
			'{gbns_pkg::REQ_ACK, 32'h0, 3'd7, 1'b1, 1'b1,
				mk_rsp(1, 0, 0, 0, gbns_pkg::TMR_NONE, 0, 1, 1)},
			'{gbns_pkg::REQ_ACK, 32'h0, 3'd4, 1'b1, 1'b1,
				mk_rsp(1, 0, 0, 0, gbns_pkg::TMR_NONE, 0, 1, 1)},
			'{gbns_pkg::REQ_TIMEOUT, 32'h0, 3'd0, 1'b0, 1'b0, '0},
			'{gbns_pkg::REQ_ACK, 32'h0, 3'd1, 1'b1, 1'b1,
				mk_rsp(1, 0, 0, 0, gbns_pkg::TMR_RESTART, 2, 0, 1)},
			'{gbns_pkg::REQ_SEND, 32'hDEADBEEF, 3'd0, 1'b0, 1'b0, '0},
			'{gbns_pkg::REQ_SEND, 32'h00000001, 3'd0, 1'b0, 1'b0, '0},
			'{gbns_pkg::REQ_TIMEOUT, 32'h0, 3'd7, 1'b1, 1'b0, '0},
			'{gbns_pkg::REQ_ACK, 32'h0, 3'd5, 1'b1, 1'b1,
				mk_rsp(1, 0, 0, 0, gbns_pkg::TMR_STOP, 2, 0, 1)},
			'{gbns_pkg::REQ_SEND, 32'h80000000, 3'd0, 1'b0, 1'b0, '0},
			'{gbns_pkg::REQ_SEND, 32'h7FFFFFFF, 3'd0, 1'b0, 1'b0, '0},
			'{gbns_pkg::REQ_SEND, 32'h0F0F0F0F, 3'd0, 1'b0, 1'b0, '0},
			'{gbns_pkg::REQ_ACK, 32'h0, 3'd7, 1'b1, 1'b1,
				mk_rsp(1, 0, 0, 0, gbns_pkg::TMR_RESTART, 0, 0, 1)},
			'{gbns_pkg::REQ_ACK, 32'h0, 3'd6, 1'b1, 1'b1,
				mk_rsp(1, 0, 0, 0, gbns_pkg::TMR_NONE, 0, 0, 1)},
			'{gbns_pkg::REQ_TIMEOUT, 32'h0, 3'd3, 1'b0, 1'b0, '0},
			'{gbns_pkg::REQ_ACK, 32'h0, 3'd0, 1'b1, 1'b1,
				mk_rsp(1, 0, 0, 0, gbns_pkg::TMR_STOP, 0, 0, 1)}
		};

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		useful = 0;
		foreach (steps[i]) begin
			put_req(steps[i].kind, steps[i].pay, steps[i].sn, steps[i].ok, steps[i].typed,
				steps[i].want, acted);
			if (acted)
				useful++;
		end

		// mostly in-span acks and sends, with timeouts, stale/corrupt acks and stray requests mixed in
		while (req_cnt < 370) begin
			pick = $urandom_range(0, 99);
			pay  = $urandom();
			sn   = gbns_pkg::SEQ_BITS'($urandom_range(0, 7));
			ok   = 1'b1;
			if (pick < 45) begin
				kind = gbns_pkg::REQ_SEND;
			end else if (pick < 82) begin
				kind = gbns_pkg::REQ_ACK;
				if (in_flight != 0 && $urandom_range(0, 3) != 0) begin
					sn = oldest_seq() + gbns_pkg::SEQ_BITS'($urandom_range(0, in_flight - 1));
					ok = ($urandom_range(0, 15) != 0);
				end else begin
					ok = 1'($urandom_range(0, 1));
				end
			end else if (pick < 94) begin
				kind = gbns_pkg::REQ_TIMEOUT;
			end else begin
				kind = REQ_BOGUS;
				ok   = 1'($urandom_range(0, 1));
			end
			put_req(kind, pay, sn, ok, 1'b0, '0, acted);
			if (acted)
				useful++;
		end
		req_valid <= 1'b0;

		while (due_rsp.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);

		$display("Requests: %0d (send %0d, ack %0d, timeout %0d, unknown %0d), %0d state-changing",
			req_cnt, kind_cnt[gbns_pkg::REQ_SEND], kind_cnt[gbns_pkg::REQ_ACK],
			kind_cnt[gbns_pkg::REQ_TIMEOUT], kind_cnt[REQ_BOGUS], useful);
		$display("Result transfers checked: %0d, mismatches: %0d", rsp_cnt, errors);
		if (errors == 0) begin
			$display("go_back_n_sender_core verification clean");
		end else begin
			$display("go_back_n_sender_core verification failed");
		end
		$finish;
	end

endmodule
